[rtl/ppts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types, constants and helpers of the trajectory sampler.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int MAX_COEFFS   = 10;
  localparam int AXES         = 3;
  localparam int TABLE_DEPTH  = MAX_SEGMENTS * AXES * MAX_COEFFS;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int VAL_W        = 48;
  localparam int TIME_W       = 24;

  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  // register indexes of the configuration port
  localparam logic [1:0] REG_POLY_MODE = 2'd0;
  localparam logic [1:0] REG_SEG_COUNT = 2'd1;
  localparam logic [1:0] REG_TIME_STEP = 2'd2;

  typedef enum logic [1:0] {
    ACT_COEFF   = 2'd0,
    ACT_DUR     = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SKIP,
    ST_DONE_OUT,
    ST_START,
    ST_RD,
    ST_M0,
    ST_M1,
    ST_QS,
    ST_ACC,
    ST_STORE,
    ST_EMIT,
    ST_ADV
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_coeff;
    logic       wr_dur;
    logic       restart;
    logic       skip_adv;
    logic       set_fin;
    logic       acc_clr;
    logic       rd_en;
    logic       mul_lo;
    logic       mul_hi;
    logic       q_ld;
    logic       acc_ld;
    logic       res_ld;
    logic       emit;
    logic       emit_done;
    logic       advance;
    logic [1:0] axis;
    logic [1:0] deriv;
    logic [3:0] cidx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       finished;
    logic       seg_ge_cnt;
    logic       time_lt_dur;
    logic       out_free;
    logic [4:0] coeff_n;
  } stat_t;

  // falling factorial p*(p-1)*...*(p-d+1)
  function automatic logic [9:0] falling(input logic [3:0] p, input logic [1:0] d);
    int f;
    f = 1;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(d)) f = f * (int'(p) - k);
    end
    return 10'(f);
  endfunction

endpackage
`default_nettype wire

[rtl/ppts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppts_ctrl
// Sequencer: segment skip, Horner walk per axis and derivative, output.
// ----------------------------------------------------------------------------
module ppts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      action,
  input  wire ppts_pkg::stat_t st,
  output ppts_pkg::cmd_t       cmd
);
  import ppts_pkg::*;

  state_t     state, state_next;
  logic [1:0] axis, deriv;
  logic [3:0] cidx;
  logic       accept;
  logic [4:0] more_lim;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // another term follows when cidx+1+deriv < n
  assign more_lim = 5'(cidx) + 5'(deriv) + 5'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && action == ACT_TICK) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (st.finished || st.seg_ge_cnt) state_next = ST_DONE_OUT;
        else if (st.time_lt_dur) state_next = ST_START;
      end
      ST_DONE_OUT: begin
        if (st.out_free && axis == LAST_AXIS) state_next = ST_IDLE;
      end
      ST_START: begin
        if (5'(deriv) < st.coeff_n) state_next = ST_RD;
        else state_next = ST_STORE;
      end
      ST_RD:  state_next = ST_M0;
      ST_M0:  state_next = ST_M1;
      ST_M1:  state_next = ST_QS;
      ST_QS:  state_next = ST_ACC;
      ST_ACC: begin
        if (more_lim < st.coeff_n) state_next = ST_RD;
        else state_next = ST_STORE;
      end
      ST_STORE: begin
        if (deriv == 2'd3) state_next = ST_EMIT;
        else state_next = ST_START;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          if (axis == LAST_AXIS) state_next = ST_ADV;
          else state_next = ST_START;
        end
      end
      ST_ADV:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.axis      = axis;
    cmd.deriv     = deriv;
    cmd.cidx      = cidx;
    cmd.wr_coeff  = accept && action == ACT_COEFF;
    cmd.wr_dur    = accept && action == ACT_DUR;
    cmd.restart   = accept && action == ACT_RESTART;
    case (state)
      ST_SKIP: begin
        if (!st.finished && st.seg_ge_cnt) cmd.set_fin = 1'b1;
        else if (!st.finished && !st.time_lt_dur) cmd.skip_adv = 1'b1;
      end
      ST_DONE_OUT: cmd.emit_done = st.out_free;
      ST_START:    cmd.acc_clr = 1'b1;
      ST_RD:       cmd.rd_en = 1'b1;
      ST_M0:       cmd.mul_lo = 1'b1;
      ST_M1:       cmd.mul_hi = 1'b1;
      ST_QS:       cmd.q_ld = 1'b1;
      ST_ACC:      cmd.acc_ld = 1'b1;
      ST_STORE:    cmd.res_ld = 1'b1;
      ST_EMIT:     cmd.emit = st.out_free;
      ST_ADV:      cmd.advance = 1'b1;
      default: ;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
      deriv <= '0;
      cidx  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          axis  <= '0;
          deriv <= '0;
        end
        ST_DONE_OUT: begin
          if (st.out_free) axis <= axis + 2'd1;
        end
        ST_START: cidx <= '0;
        ST_ACC:   cidx <= cidx + 4'd1;
        ST_STORE: deriv <= deriv + 2'd1;
        ST_EMIT: begin
          if (st.out_free) begin
            axis  <= axis + 2'd1;
            deriv <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ppts_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppts_dp
// Tables, sampler state, shared multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module ppts_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ppts_pkg::cmd_t       cmd,
  output ppts_pkg::stat_t           st,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic [3:0]           seg_index,
  input  wire logic [1:0]           axis_index,
  input  wire logic [3:0]           coeff_index,
  input  wire logic signed [31:0]   write_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_axis,
  output logic [3:0]                out_segment,
  output logic signed [47:0]        position,
  output logic signed [47:0]        velocity,
  output logic signed [47:0]        acceleration,
  output logic signed [47:0]        jerk_value,
  output logic                      done_res,
  output logic                      last
);
  import ppts_pkg::*;

  localparam logic signed [57:0] SAT_HI = 58'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [57:0] SAT_LO = -58'sh0_8000_0000_0000;

  // configuration registers
  logic [2:0]  poly_mode;
  logic [4:0]  segment_count;
  logic [15:0] time_step;

  // sampler state
  logic [4:0]        cur_seg;
  logic [TIME_W-1:0] sample_time;
  logic              finished;

  // tables
  logic [31:0]       coeff_mem [TABLE_DEPTH];
  logic [TIME_W-1:0] dur [MAX_SEGMENTS];
  logic signed [31:0] coeff_q;

  // arithmetic
  logic signed [VAL_W-1:0] acc;
  logic signed [41:0]      term;
  logic [47:0]             prod_lo, prod_hi;
  logic [55:0]             q;
  logic                    neg, neg_q;
  logic [47:0]             mag;
  logic [71:0]             full;
  logic signed [57:0]      sum;
  logic signed [VAL_W-1:0] res [4];

  logic [2:0]        mode_c;
  logic [4:0]        cnt;
  logic [TIME_W-1:0] cur_dur;
  logic [TIME_W:0]   next_time;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              wr_ok;
  logic [9:0]        fall;
  logic [3:0]        pow;

  // clamped mode and segment count
  always_comb begin
    mode_c = poly_mode;
    if (poly_mode == 3'd0) mode_c = 3'd1;
    else if (poly_mode > 3'(MAX_COEFFS / 2)) mode_c = 3'(MAX_COEFFS / 2);
  end
  assign cnt = (segment_count > 5'(MAX_SEGMENTS)) ? 5'(MAX_SEGMENTS) : segment_count;

  assign cur_dur   = dur[cur_seg[3:0]];
  assign next_time = {1'b0, sample_time} + (TIME_W + 1)'(time_step);

  assign st.finished    = finished;
  assign st.seg_ge_cnt  = (cur_seg >= cnt);
  assign st.time_lt_dur = (sample_time < cur_dur);
  assign st.out_free    = !out_valid || !out_stall;
  assign st.coeff_n     = {1'b0, mode_c, 1'b0};

  // table addresses
  assign wr_ok = (axis_index < 2'(AXES)) && (coeff_index < 4'(MAX_COEFFS));
  assign waddr = ADDR_W'(seg_index) * ADDR_W'(AXES * MAX_COEFFS)
               + ADDR_W'(axis_index) * ADDR_W'(MAX_COEFFS) + ADDR_W'(coeff_index);
  assign raddr = ADDR_W'(cur_seg[3:0]) * ADDR_W'(AXES * MAX_COEFFS)
               + ADDR_W'(cmd.axis) * ADDR_W'(MAX_COEFFS) + ADDR_W'(cmd.cidx);

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.wr_coeff && wr_ok) coeff_mem[waddr] <= write_value;
    if (cmd.rd_en) coeff_q <= coeff_mem[raddr];
  end

  // duration table, saturated to 24 bits
  always_ff @(posedge clk) begin
    if (cmd.wr_dur) begin
      if (write_value[31:TIME_W] != '0) dur[seg_index] <= '1;
      else dur[seg_index] <= write_value[TIME_W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_mode     <= 3'd4;
      segment_count <= 5'd1;
      time_step     <= 16'd655;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLY_MODE: poly_mode     <= cfg_data[2:0];
        REG_SEG_COUNT: segment_count <= cfg_data[4:0];
        REG_TIME_STEP: time_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // segment and time
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_seg     <= '0;
      sample_time <= '0;
      finished    <= 1'b0;
    end else if (cmd.restart) begin
      cur_seg     <= '0;
      sample_time <= '0;
      finished    <= 1'b0;
    end else if (cmd.set_fin) begin
      finished <= 1'b1;
    end else if (cmd.skip_adv) begin
      cur_seg     <= cur_seg + 5'd1;
      sample_time <= '0;
    end else if (cmd.advance) begin
      if (next_time >= {1'b0, cur_dur}) begin
        cur_seg     <= cur_seg + 5'd1;
        sample_time <= '0;
        if (cur_seg + 5'd1 >= cnt) finished <= 1'b1;
      end else begin
        sample_time <= next_time[TIME_W-1:0];
      end
    end
  end

  // horner step: term, magnitude times time, truncate, add, saturate
  assign pow  = 4'(st.coeff_n - 5'd1 - 5'(cmd.cidx));
  assign fall = falling(pow, cmd.deriv);
  assign neg  = acc[VAL_W-1];
  assign mag  = neg ? 48'(-acc) : 48'(acc);
  assign full = {prod_hi, 24'd0} + {24'd0, prod_lo};
  assign sum  = (neg_q ? -58'(signed'({2'b0, q})) : 58'(signed'({2'b0, q})))
              + 58'(signed'({term, 8'd0}));

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc <= '0;
    if (cmd.mul_lo) begin
      prod_lo <= mag[23:0] * sample_time;
      term    <= 42'(coeff_q) * 42'(signed'({1'b0, fall}));
    end
    if (cmd.mul_hi) prod_hi <= mag[47:24] * sample_time;
    if (cmd.q_ld) begin
      q     <= full[71:16];
      neg_q <= neg;
    end
    if (cmd.acc_ld) begin
      if (sum > SAT_HI) acc <= SAT_HI[VAL_W-1:0];
      else if (sum < SAT_LO) acc <= SAT_LO[VAL_W-1:0];
      else acc <= sum[VAL_W-1:0];
    end
    if (cmd.res_ld) res[cmd.deriv] <= acc;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_done) begin
      out_axis <= cmd.axis;
      last     <= (cmd.axis == LAST_AXIS);
      done_res <= cmd.emit_done;
      if (cmd.emit) begin
        out_segment  <= cur_seg[3:0];
        position     <= res[0];
        velocity     <= res[1];
        acceleration <= res[2];
        jerk_value   <= res[3];
      end else begin
        out_segment  <= '0;
        position     <= '0;
        velocity     <= '0;
        acceleration <= '0;
        jerk_value   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/piecewise_poly_trajectory_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_sampler
// Samples position and three derivatives of a piecewise polynomial path.
// ----------------------------------------------------------------------------
// Write words load coefficients and durations, and restart returns to the
// first segment. A tick word first skips elapsed segments, then runs a
// Horner walk per axis and derivative on one shared multiply-accumulate
// unit, each coefficient passing through read, low multiply, high multiply,
// truncate and accumulate, with n = 2*poly_mode coefficients and poly_mode
// clamped to 1..5; an output stall holds the walk before each word. A tick
// past the last segment gives its three done words. Input and
// configuration writes are held off while a tick is in progress.
module piecewise_poly_trajectory_sampler (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          action,
  input  wire logic [3:0]          seg_index,
  input  wire logic [1:0]          axis_index,
  input  wire logic [3:0]          coeff_index,
  input  wire logic signed [31:0]  write_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_axis,
  output logic [3:0]               out_segment,
  output logic signed [47:0]       position,
  output logic signed [47:0]       velocity,
  output logic signed [47:0]       acceleration,
  output logic signed [47:0]       jerk_value,
  output logic                     done_res,
  output logic                     last
);
  import ppts_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // config writes only land while idle
  assign cfg_ready = !in_stall;

  ppts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .st       (st),
    .cmd      (cmd)
  );

  ppts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .seg_index    (seg_index),
    .axis_index   (axis_index),
    .coeff_index  (coeff_index),
    .write_value  (write_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_axis     (out_axis),
    .out_segment  (out_segment),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration),
    .jerk_value   (jerk_value),
    .done_res     (done_res),
    .last         (last)
  );

endmodule
`default_nettype wire

[rtl/ppts_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppts_chk
// Port-level checks of the trajectory sampler.
// ----------------------------------------------------------------------------
module ppts_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_axis,
  input wire logic signed [47:0] position,
  input wire logic signed [47:0] velocity,
  input wire logic signed [47:0] acceleration,
  input wire logic signed [47:0] jerk_value,
  input wire logic               done_res,
  input wire logic               last
);
  import ppts_pkg::*;

  // no word right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(out_axis))
    else $error("stalled output word changed");

  // last marks the final axis only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (out_axis == LAST_AXIS)))
    else $error("last flag does not match axis");

  // done words carry zero values
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> position == 0 && velocity == 0
      && acceleration == 0 && jerk_value == 0)
    else $error("done word with nonzero values");

  // no new input while a word waits in the middle of a tick
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && in_valid |-> in_stall)
    else $error("input taken during a tick");

endmodule

bind piecewise_poly_trajectory_sampler ppts_chk u_ppts_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_axis     (out_axis),
  .position     (position),
  .velocity     (velocity),
  .acceleration (acceleration),
  .jerk_value   (jerk_value),
  .done_res     (done_res),
  .last         (last)
);
`default_nettype wire

[dv/piecewise_poly_trajectory_sampler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_sampler_tb
// Loads coefficient and duration tables, runs ticks over several register
// settings and compares every output word with a local trajectory predictor.
// ----------------------------------------------------------------------------
module piecewise_poly_trajectory_sampler_tb;
  import ppts_pkg::*;

  typedef struct packed {
    action_t            act;
    logic [3:0]         seg;
    logic [1:0]         axis;
    logic [3:0]         cidx;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         axis;
    logic [3:0]         seg;
    logic signed [47:0] pos;
    logic signed [47:0] vel;
    logic signed [47:0] acc;
    logic signed [47:0] jerk;
    logic               done;
    logic               lst;
  } sample_t;

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
  localparam int     CYCLE_LIMIT = 2000000;
  localparam int     LIVE_SEGS = 2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [3:0] seg_index = '0;
  logic [1:0] axis_index = '0;
  logic [3:0] coeff_index = '0;
  logic signed [31:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_axis;
  logic [3:0] out_segment;
  logic signed [47:0] position, velocity, acceleration, jerk_value;
  logic done_res, last;

  piecewise_poly_trajectory_sampler u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .seg_index(seg_index), .axis_index(axis_index), .coeff_index(coeff_index),
    .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_axis(out_axis),
    .out_segment(out_segment), .position(position), .velocity(velocity),
    .acceleration(acceleration), .jerk_value(jerk_value), .done_res(done_res),
    .last(last)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] coeff_mem [MAX_SEGMENTS*AXES*MAX_COEFFS];
  logic [23:0] dur_mem [MAX_SEGMENTS];
  int unsigned cur_seg, samp_time, cur_mode, cur_count, cur_step;
  bit          all_done;

  cmd_word_t pending_words[$];
  sample_t   expected_samples[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  int        hold_cycles = 0;
  bit        in_taken = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic longint sat48(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // acc times unsigned Q8.16 time, magnitude truncated
  function automatic longint scale_by_time(input longint a, input int unsigned t);
    logic [127:0] mag;
    longint r;
    mag = (a < 0) ? 128'(-a) : 128'(a);
    mag = (mag * 128'(t)) >> 16;
    r = longint'(mag[63:0]);
    return (a < 0) ? -r : r;
  endfunction

  function automatic longint horner_deriv(input int base, input int n, input int d,
                                          input int unsigned t);
    longint acc, term, fall;
    int p;
    acc = 0;
    if (n <= d) return 0;
    for (int i = 0; i + d < n; i++) begin
      p = n - 1 - i;
      fall = 1;
      for (int k = 0; k < d; k++) fall = fall * (p - k);
      term = longint'($signed(coeff_mem[base + i])) * fall * 256;
      acc = sat48(scale_by_time(acc, t) + term);
    end
    return acc;
  endfunction

  task automatic predict_word(input cmd_word_t w);
    int unsigned cnt, nxt;
    int n, base;
    sample_t s;
    cnt = (cur_count > MAX_SEGMENTS) ? MAX_SEGMENTS : cur_count;
    case (w.act)
      ACT_COEFF: begin
        if (w.axis < AXES && w.cidx < MAX_COEFFS)
          coeff_mem[(w.seg*AXES + w.axis)*MAX_COEFFS + w.cidx] = w.value;
      end
      ACT_DUR: begin
        dur_mem[w.seg] = (w.value[31:24] != 0) ? 24'hFFFFFF : w.value[23:0];
      end
      ACT_RESTART: begin
        cur_seg = 0; samp_time = 0; all_done = 0;
      end
      default: begin
        // skip elapsed segments
        while (!all_done) begin
          if (cur_seg >= cnt) begin
            all_done = 1;
            break;
          end
          if (samp_time < dur_mem[cur_seg]) break;
          cur_seg++;
          samp_time = 0;
        end
        if (all_done) begin
          for (int a = 0; a < AXES; a++) begin
            s = '0;
            s.axis = 2'(a); s.done = 1; s.lst = (a == AXES-1);
            expected_samples.insert(expected_samples.size(), s);
          end
        end else begin
          n = 2 * ((cur_mode < 1) ? 1 : (cur_mode > 5) ? 5 : cur_mode);
          for (int a = 0; a < AXES; a++) begin
            base = (cur_seg*AXES + a)*MAX_COEFFS;
            s.axis = 2'(a); s.seg = 4'(cur_seg);
            s.pos  = 48'(horner_deriv(base, n, 0, samp_time));
            s.vel  = 48'(horner_deriv(base, n, 1, samp_time));
            s.acc  = 48'(horner_deriv(base, n, 2, samp_time));
            s.jerk = 48'(horner_deriv(base, n, 3, samp_time));
            s.done = 0; s.lst = (a == AXES-1);
            expected_samples.insert(expected_samples.size(), s);
          end
          nxt = samp_time + cur_step;
          if (nxt >= dur_mem[cur_seg]) begin
            cur_seg++;
            samp_time = 0;
            if (cur_seg >= cnt) all_done = 1;
          end else begin
            samp_time = nxt;
          end
        end
      end
    endcase
  endtask

  // input driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) predict_word(pending_words.pop_front());
      if (in_valid && !in_taken) begin
        // hold the word
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
        in_valid    <= 1'b1;
        action      <= pending_words[0].act;
        seg_index   <= pending_words[0].seg;
        axis_index  <= pending_words[0].axis;
        coeff_index <= pending_words[0].cidx;
        write_value <= pending_words[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept tracking at the rising edge, prediction done at next falling edge
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // output stall: random bursts plus a long hold-off
  int out_gap = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk) begin
    sample_t got, want;
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      got = {out_axis, out_segment, position, velocity, acceleration, jerk_value,
             done_res, last};
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected word axis %0d", out_axis));
      end else begin
        want = expected_samples.pop_front();
        if (got.axis != want.axis) report($sformatf("axis %0d/%0d", got.axis, want.axis));
        if (got.seg != want.seg) report($sformatf("segment %0d/%0d", got.seg, want.seg));
        if (got.pos != want.pos) report($sformatf("position %0h/%0h", got.pos, want.pos));
        if (got.vel != want.vel) report($sformatf("velocity %0h/%0h", got.vel, want.vel));
        if (got.acc != want.acc) report($sformatf("accel %0h/%0h", got.acc, want.acc));
        if (got.jerk != want.jerk) report($sformatf("jerk %0h/%0h", got.jerk, want.jerk));
        if (got.done != want.done) report($sformatf("done %0b/%0b", got.done, want.done));
        if (got.lst != want.lst) report($sformatf("last %0b/%0b", got.lst, want.lst));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_word(input action_t a, input int s, input int ax, input int c,
                           input logic [31:0] v);
    cmd_word_t w;
    w.act = a; w.seg = 4'(s); w.axis = 2'(ax); w.cidx = 4'(c); w.value = v;
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // wait until all queued words are accepted and results drained
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POLY_MODE: cur_mode  = val[2:0];
      REG_SEG_COUNT: cur_count = val[4:0];
      REG_TIME_STEP: cur_step  = val;
      default: ;
    endcase
  endtask

  // fill the live segments and zero every other duration so no undefined
  // entry is read
  task automatic load_tables(input int max_dur);
    for (int s = 0; s < LIVE_SEGS; s++) begin
      for (int a = 0; a < AXES; a++)
        for (int c = 0; c < MAX_COEFFS; c++)
          push_word(ACT_COEFF, s, a, c, rand_coeff());
    end
    for (int s = 0; s < MAX_SEGMENTS; s++)
      push_word(ACT_DUR, s, 0, 0, (s < LIVE_SEGS) ? $urandom_range(1, max_dur) : 0);
  endtask

  initial begin
    int phase_ticks;
    cur_seg = 0; samp_time = 0; all_done = 0;
    cur_mode = 4; cur_count = 1; cur_step = 655;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tables, extremes, out-of-range writes, restart, done
    load_tables(4000);
    push_word(ACT_DUR, 0, 0, 0, 32'hFFFFFFFF);
    push_word(ACT_DUR, 1, 0, 0, 32'd0);
    push_word(ACT_COEFF, 15, 3, 9, 32'h12345678);
    push_word(ACT_COEFF, 2, 1, 15, 32'h5A5A5A5A);
    push_word(ACT_COEFF, 0, 2, 0, 32'h7FFFFFFF);
    push_word(ACT_COEFF, 0, 1, 9, 32'h80000000);
    push_word(ACT_TICK, 0, 0, 0, 0);
    push_word(ACT_TICK, 5, 2, 3, 32'hFFFFFFFF);
    push_word(ACT_DUR, 0, 0, 0, 32'd100);
    push_word(ACT_RESTART, 0, 0, 0, 0);
    push_word(ACT_TICK, 0, 0, 0, 0);
    push_word(ACT_TICK, 0, 0, 0, 0);
    push_word(ACT_TICK, 0, 0, 0, 0);
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_POLY_MODE, 16'd1); write_reg(REG_SEG_COUNT, 16'd16);
                 write_reg(REG_TIME_STEP, 16'hFFFF); end
        1: begin write_reg(REG_POLY_MODE, 16'd5); write_reg(REG_SEG_COUNT, 16'd0);
                 write_reg(REG_TIME_STEP, 16'd1); end
        2: begin write_reg(REG_POLY_MODE, 16'd0); write_reg(REG_SEG_COUNT, 16'd31);
                 write_reg(REG_TIME_STEP, 16'd0); end
        3: begin write_reg(REG_POLY_MODE, 16'd7); write_reg(REG_SEG_COUNT, 16'd3);
                 write_reg(REG_TIME_STEP, 16'd20000); write_reg(REG_UNUSED, 16'hFFFF); end
        default: begin
          write_reg(REG_POLY_MODE, 16'($urandom_range(1, 3)));
          write_reg(REG_SEG_COUNT, 16'($urandom_range(1, 16)));
          write_reg(REG_TIME_STEP, 16'($urandom_range(1, 65535)));
        end
      endcase
      if (ph == 5) calm = 1'b1;
      if (ph == 4) hold_cycles = 400;
      push_word(ACT_RESTART, 0, 0, 0, 0);
      phase_ticks = 0;
      while (phase_ticks < 4) begin
        case ($urandom_range(0, 9))
          0: push_word(ACT_COEFF, $urandom_range(0, 15), $urandom_range(0, 3),
                       $urandom_range(0, 15), rand_coeff());
          // durations only change on the live segments
          1: push_word(ACT_DUR, $urandom_range(0, LIVE_SEGS - 1), 0, 0,
                       ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 200000));
          2: push_word(ACT_RESTART, $urandom_range(0, 15), $urandom_range(0, 3),
                       $urandom_range(0, 15), $urandom());
          default: begin
            push_word(ACT_TICK, $urandom_range(0, 15), $urandom_range(0, 3),
                      $urandom_range(0, 15), $urandom());
            phase_ticks++;
          end
        endcase
      end
      drain();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ppts_pkg.sv
rtl/ppts_ctrl.sv
rtl/ppts_dp.sv
rtl/piecewise_poly_trajectory_sampler.sv
rtl/ppts_chk.sv
dv/piecewise_poly_trajectory_sampler_tb.sv
